### hw/rtl/swm_pkg.sv
// Shared types and constants of the summed-area table window mean unit.
`timescale 1ns / 1ps

package swm_pkg;

  // Fixed field widths.
  localparam int unsigned SIDE_W  = 7;   // configuration register width
  localparam int unsigned COORD_W = 6;   // row and col input fields
  localparam int unsigned VAL_W   = 48;  // table entries and the mean
  localparam int unsigned SUM_W   = VAL_W + 1;        // window sum after saturation
  localparam int unsigned ACC_W   = VAL_W + 3;        // signed corner accumulator
  localparam int unsigned DVS_W   = 2 * SIDE_W;       // window_side squared
  localparam int unsigned CNT_W   = $clog2(SUM_W);    // divider step counter
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_W   = SIDE_W + 1;       // row + window_side - 1

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIDE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLACEMENTS_SIDE = 2'd2;

  // Request operations.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Table corners in read order.
  typedef enum logic [1:0] {
    CORNER_BR   = 2'd0,  // bottom-right, added
    CORNER_UP   = 2'd1,  // above the window, subtracted
    CORNER_LEFT = 2'd2,  // left of the window, subtracted
    CORNER_UL   = 2'd3   // above-left, added
  } corner_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/sat_window_mean_unit.sv
// Top level of the summed-area table window mean unit.
`timescale 1ns / 1ps

// The unit holds one square summed-area table in a single-port memory and
// answers box-mean queries over it. A request is taken at a clock edge with
// start high and busy low. A load request (operation 0) writes cell_value at
// (row, col) in that same edge and produces no result; busy stays low, so
// loads go at one per cycle. A query request (operation 1) produces exactly
// one result, shown on mean_o and status_o for one cycle with out_strobe_o.
// A query whose placement falls outside the table or the placement range
// answers in the next cycle with status 1 and mean 0, again without busy.
// A valid query reads those of its four corners that exist through the one
// memory port, one after another, accumulating each as its read data lands,
// and then runs a bit-serial divider by window_side squared, one quotient
// bit per cycle for 49 bits. Busy is high until the result is shown, and a
// new request may be taken in the cycle the result is shown.
// The receiver cannot hold results off, so none are ever queued. Reset sets
// window_side to 1 and both other sides to 64 (limited to MAX_TABLE_SIDE);
// the table contents are not cleared and must be loaded before use.
// Configuration writes are taken at any edge with cfg_we_i high.
module sat_window_mean_unit #(
  parameter int unsigned MAX_TABLE_SIDE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [swm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [swm_pkg::SIDE_W-1:0]        cfg_wdata_i,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation_i,
  input  logic [swm_pkg::COORD_W-1:0]       row_i,
  input  logic [swm_pkg::COORD_W-1:0]       col_i,
  input  logic [swm_pkg::VAL_W-1:0]         cell_value_i,
  output logic                              out_strobe_o,
  output logic [swm_pkg::VAL_W-1:0]         mean_o,
  output logic                              status_o
);

  import swm_pkg::*;

  localparam int unsigned DEPTH    = MAX_TABLE_SIDE * MAX_TABLE_SIDE;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SIDE_RST = (MAX_TABLE_SIDE < 64) ? MAX_TABLE_SIDE : 64;

  // Out-of-range register writes are pulled into 1 .. MAX_TABLE_SIDE.
  function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > MAX_TABLE_SIDE) begin
      r = SIDE_W'(MAX_TABLE_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Row-major address with a row stride of MAX_TABLE_SIDE.
  function automatic logic [ADDR_W-1:0] cell_addr(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_TABLE_SIDE) + ADDR_W'(c);
  endfunction

  // Configuration registers.
  logic [SIDE_W-1:0] win_side_q, tab_side_q, plc_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_side_q <= SIDE_W'(1);
      tab_side_q <= SIDE_W'(SIDE_RST);
      plc_side_q <= SIDE_W'(SIDE_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SIDE:     win_side_q <= clamp_side(cfg_wdata_i);
        CFG_TABLE_SIDE:      tab_side_q <= clamp_side(cfg_wdata_i);
        CFG_PLACEMENTS_SIDE: plc_side_q <= clamp_side(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic                accept;
  logic                is_query;
  logic                in_range;
  logic [POS_W-1:0]    row_last_in, col_last_in;
  logic                load_ok;

  logic [COORD_W-1:0]  row_q, col_q;
  logic [1:0]          corner_q, corner_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [DVS_W-1:0]    cells_q;

  // Tag of the read in flight: its data lands in the cycle after the address.
  logic                tag_vld_q, tag_vld_d;
  logic                tag_neg_q, tag_neg_d;

  logic [POS_W-1:0]    row_last, col_last, row_up, col_up;
  logic [POS_W-1:0]    rd_row, rd_col;
  logic                rd_en, rd_neg;

  logic                mem_en, mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [VAL_W-1:0]    mem_rdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [SUM_W-1:0]    sum_sat;

  logic                strobe_q, strobe_d;
  logic [VAL_W-1:0]    mean_q, mean_d;
  logic                status_q, status_d;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign is_query = (operation_i == OP_QUERY);

  assign row_last_in = POS_W'(row_i) + POS_W'(win_side_q) - POS_W'(1);
  assign col_last_in = POS_W'(col_i) + POS_W'(win_side_q) - POS_W'(1);
  assign in_range    = (SIDE_W'(row_i) < plc_side_q) && (SIDE_W'(col_i) < plc_side_q) &&
                       (row_last_in < POS_W'(tab_side_q)) &&
                       (col_last_in < POS_W'(tab_side_q));
  assign load_ok     = (32'(row_i) < MAX_TABLE_SIDE) && (32'(col_i) < MAX_TABLE_SIDE);

  // Corner coordinates of the captured placement. The row and column above
  // or left of the window are only read when they exist.
  assign row_last = POS_W'(row_q) + POS_W'(win_side_q) - POS_W'(1);
  assign col_last = POS_W'(col_q) + POS_W'(win_side_q) - POS_W'(1);
  assign row_up   = POS_W'(row_q) - POS_W'(1);
  assign col_up   = POS_W'(col_q) - POS_W'(1);

  always_comb begin
    rd_row = row_last;
    rd_col = col_last;
    rd_en  = 1'b1;
    rd_neg = 1'b0;
    case (corner_e'(corner_q))
      CORNER_BR: begin
        rd_row = row_last;
        rd_col = col_last;
      end
      CORNER_UP: begin
        rd_row = row_up;
        rd_col = col_last;
        rd_en  = (row_q != '0);
        rd_neg = 1'b1;
      end
      CORNER_LEFT: begin
        rd_row = row_last;
        rd_col = col_up;
        rd_en  = (col_q != '0);
        rd_neg = 1'b1;
      end
      CORNER_UL: begin
        rd_row = row_up;
        rd_col = col_up;
        rd_en  = (row_q != '0) && (col_q != '0);
      end
      default: ;
    endcase
  end

  // A negative corner combination saturates to zero.
  assign sum_sat = acc_q[ACC_W-1] ? '0 : acc_q[SUM_W-1:0];

  always_comb begin
    state_d   = state_q;
    corner_d  = corner_q;
    acc_d     = acc_q;
    tag_vld_d = 1'b0;
    tag_neg_d = 1'b0;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cell_addr(POS_W'(row_i), POS_W'(col_i));
    strobe_d  = 1'b0;
    mean_d    = '0;
    status_d  = STATUS_OK;
    div_req.start    = 1'b0;
    div_req.dividend = sum_sat;
    div_req.divisor  = cells_q;

    // Accumulate the corner whose read data arrives in this cycle.
    if (tag_vld_q) begin
      if (tag_neg_q) begin
        acc_d = acc_q - ACC_W'(mem_rdata);
      end else begin
        acc_d = acc_q + ACC_W'(mem_rdata);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!is_query) begin
            mem_en = load_ok;
            mem_we = 1'b1;
          end else if (!in_range) begin
            strobe_d = 1'b1;
            status_d = STATUS_RANGE;
          end else begin
            acc_d    = '0;
            corner_d = CORNER_BR;
            state_d  = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_en    = rd_en;
        mem_addr  = cell_addr(rd_row, rd_col);
        tag_vld_d = rd_en;
        tag_neg_d = rd_neg;
        corner_d  = corner_q + 2'd1;
        if (corner_e'(corner_q) == CORNER_UL) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          strobe_d = 1'b1;
          mean_d   = div_rsp.quotient[VAL_W-1:0];
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tag_vld_q <= 1'b0;
      strobe_q  <= 1'b0;
      corner_q  <= '0;
    end else begin
      state_q   <= state_d;
      tag_vld_q <= tag_vld_d;
      strobe_q  <= strobe_d;
      corner_q  <= corner_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_neg_q <= tag_neg_d;
    acc_q     <= acc_d;
    mean_q    <= mean_d;
    status_q  <= status_d;
    cells_q   <= DVS_W'(win_side_q) * DVS_W'(win_side_q);
    if (accept) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  swm_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (VAL_W)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (cell_value_i),
    .rdata_o (mem_rdata)
  );

  swm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_strobe_o = strobe_q;
  assign mean_o       = mean_q;
  assign status_o     = status_q;

endmodule

### hw/rtl/swm_mem.sv
// Single-port synchronous table memory with a registered read.
`timescale 1ns / 1ps

module swm_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 48
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/swm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module swm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swm_pkg::div_req_t req_i,
  output swm_pkg::div_rsp_t rsp_o
);

  import swm_pkg::*;

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(SUM_W - 1);
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      // The remainder stays below the divisor, so it fits DVS_W bits.
      rem_d = fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
